### rtl/symmetric_hash_join_counter_defines.svh
// Assertion helpers shared by the join counter RTL.
// Each expects clk and rst_n in scope.
`ifndef SYMMETRIC_HASH_JOIN_COUNTER_DEFINES_SVH
`define SYMMETRIC_HASH_JOIN_COUNTER_DEFINES_SVH

// Condition holds at every edge out of reset.
`define SHJ_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SHJ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHJ_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/shj_pkg.sv
package shj_pkg;

  localparam int NUM_BUCKETS  = 256;
  localparam int BUCKET_DEPTH = 16;
  localparam int SLOT_COUNT   = NUM_BUCKETS * BUCKET_DEPTH;

  localparam int KEY_W   = 32;
  localparam int TOTAL_W = 32;
  localparam int MATCH_W = 5;
  localparam int CNT_CFG_W = 9;
  localparam int DEP_CFG_W = 5;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 9;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int DIV_W  = $clog2(NUM_BUCKETS + 1);

  // remainder unit: key bits consumed per cycle
  localparam int DIV_BITS = 8;
  localparam int DIV_CYC  = KEY_W / DIV_BITS;
  localparam int DIVC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  localparam logic [CIDX_W-1:0] REG_BUCKET_COUNT = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_BUCKET_DEPTH = CIDX_W'(1);

  localparam logic [CNT_CFG_W-1:0] BUCKET_COUNT_RST = CNT_CFG_W'(256);
  localparam logic [DEP_CFG_W-1:0] BUCKET_DEPTH_RST = DEP_CFG_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_FRD,
    ST_CHECK,
    ST_SCAN,
    ST_CLR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic fill_rd;
    logic check;
    logic scan;
    logic clear;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic div_last;
    logic scan_more;
    logic cmp_pend;
    logic out_free;
  } stat_t;

  function automatic logic [DIV_W-1:0] eff_count(input logic [CNT_CFG_W-1:0] v);
    logic [DIV_W-1:0] r;
    if (v == '0) begin
      r = DIV_W'(1);
    end else if (32'(v) > NUM_BUCKETS) begin
      r = DIV_W'(NUM_BUCKETS);
    end else begin
      r = DIV_W'(v);
    end
    return r;
  endfunction

  function automatic logic [FILL_W-1:0] eff_depth(input logic [DEP_CFG_W-1:0] v);
    logic [FILL_W-1:0] r;
    if (v == '0) begin
      r = FILL_W'(1);
    end else if (32'(v) > BUCKET_DEPTH) begin
      r = FILL_W'(BUCKET_DEPTH);
    end else begin
      r = FILL_W'(v);
    end
    return r;
  endfunction

endpackage

### rtl/shj_ctrl.sv
module shj_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  shj_pkg::stat_t st,
  output shj_pkg::cmd_t  cmd
);

  shj_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shj_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shj_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = st.in_op ? shj_pkg::ST_CLR : shj_pkg::ST_HASH;
        end
      end
      shj_pkg::ST_HASH: begin
        if (st.div_last) begin
          state_nxt = shj_pkg::ST_FRD;
        end
      end
      shj_pkg::ST_FRD:   state_nxt = shj_pkg::ST_CHECK;
      shj_pkg::ST_CHECK: state_nxt = shj_pkg::ST_SCAN;
      shj_pkg::ST_SCAN: begin
        if (!st.scan_more && !st.cmp_pend) begin
          state_nxt = shj_pkg::ST_FIN;
        end
      end
      shj_pkg::ST_CLR:   state_nxt = shj_pkg::ST_FIN;
      shj_pkg::ST_FIN: begin
        if (st.out_free) begin
          state_nxt = shj_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shj_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      shj_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      shj_pkg::ST_HASH:  cmd.div_step = 1'b1;
      shj_pkg::ST_FRD:   cmd.fill_rd  = 1'b1;
      shj_pkg::ST_CHECK: cmd.check    = 1'b1;
      shj_pkg::ST_SCAN:  cmd.scan     = 1'b1;
      shj_pkg::ST_CLR:   cmd.clear    = 1'b1;
      shj_pkg::ST_FIN:   cmd.finish   = st.out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/shj_dp.sv
`include "symmetric_hash_join_counter_defines.svh"

module shj_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_tuser,   // op, side
  input  logic [shj_pkg::KEY_W-1:0]     in_tdata,   // key
  input  logic                          in_tlast,   // last_in_batch
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // tuple_matches, batch_matches, overflow
  output logic                          out_tlast,  // batch_done
  input  logic                          cfg_we,
  input  logic [shj_pkg::CIDX_W-1:0]    cfg_addr,
  input  logic [shj_pkg::CDATA_W-1:0]   cfg_wdata,
  input  shj_pkg::cmd_t                 cmd,
  output shj_pkg::stat_t                st
);

  localparam int FW = shj_pkg::FILL_W;

  // config
  logic [shj_pkg::CNT_CFG_W-1:0] bcount_r;
  logic [shj_pkg::DEP_CFG_W-1:0] bdepth_r;

  // item
  logic                      op_r, side_r, last_r;
  logic [shj_pkg::KEY_W-1:0] key_r;

  // remainder unit
  logic [shj_pkg::DIV_W-1:0]  div_r, rem_r, rem_nxt;
  logic [shj_pkg::KEY_W-1:0]  dkey_r, dkey_nxt;
  logic [shj_pkg::DIVC_W-1:0] dcnt_r;
  logic [shj_pkg::DIV_W:0]    dtmp;

  // fill store: one row per bucket, left count low, right count high
  logic [2*FW-1:0]              fill_mem [shj_pkg::NUM_BUCKETS];
  logic [shj_pkg::NUM_BUCKETS-1:0] vld_r;
  logic [2*FW-1:0]              fill_q, row, row_new;
  logic                         fvld_q;
  logic [FW-1:0]                own_fill, other_fill, depth_r;
  logic                         ovf, ovf_r;

  // key stores, slot s of bucket b at b * BUCKET_DEPTH + s
  logic [shj_pkg::KEY_W-1:0] lkey_mem [shj_pkg::SLOT_COUNT];
  logic [shj_pkg::KEY_W-1:0] rkey_mem [shj_pkg::SLOT_COUNT];
  logic [shj_pkg::KEY_W-1:0] key_q;

  logic [shj_pkg::BKT_W-1:0]  bkt;
  logic [shj_pkg::ADDR_W-1:0] base, wr_addr, rd_addr;
  logic [FW-1:0]              scan_r, s_r, matches_r;
  logic                       cmp_v_r, issue;

  logic [shj_pkg::TOTAL_W-1:0] total_r, total_sat;
  logic [shj_pkg::TOTAL_W:0]   total_sum;

  logic                        out_valid_r;
  logic [shj_pkg::MATCH_W-1:0] o_match_r;
  logic [shj_pkg::TOTAL_W-1:0] o_batch_r;
  logic                        o_done_r, o_ovf_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= shj_pkg::BUCKET_COUNT_RST;
      bdepth_r <= shj_pkg::BUCKET_DEPTH_RST;
    end else if (cfg_we) begin
      if (cfg_addr == shj_pkg::REG_BUCKET_COUNT) begin
        bcount_r <= cfg_wdata;
      end else if (cfg_addr == shj_pkg::REG_BUCKET_DEPTH) begin
        bdepth_r <= cfg_wdata[shj_pkg::DEP_CFG_W-1:0];
      end
    end
  end

  // key mod bucket count, DIV_BITS restoring steps per cycle, msb first
  always_comb begin
    rem_nxt  = rem_r;
    dkey_nxt = dkey_r;
    dtmp     = '0;
    for (int i = 0; i < shj_pkg::DIV_BITS; i++) begin
      dtmp     = {rem_nxt, dkey_nxt[shj_pkg::KEY_W-1]};
      dkey_nxt = dkey_nxt << 1;
      if (dtmp >= {1'b0, div_r}) begin
        dtmp = dtmp - {1'b0, div_r};
      end
      rem_nxt = dtmp[shj_pkg::DIV_W-1:0];
    end
  end

  assign bkt  = rem_r[shj_pkg::BKT_W-1:0];
  assign base = shj_pkg::ADDR_W'(bkt) * shj_pkg::ADDR_W'(shj_pkg::BUCKET_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser[0];
      side_r  <= in_tuser[1];
      key_r   <= in_tdata;
      last_r  <= in_tlast;
      dkey_r  <= in_tdata;
      rem_r   <= '0;
      div_r   <= shj_pkg::eff_count(bcount_r);
      depth_r <= shj_pkg::eff_depth(bdepth_r);
    end else if (cmd.div_step) begin
      dkey_r <= dkey_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.load) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // fill lookup and update
  assign row        = fvld_q ? fill_q : '0;
  assign own_fill   = side_r ? row[2*FW-1:FW] : row[FW-1:0];
  assign other_fill = side_r ? row[FW-1:0]    : row[2*FW-1:FW];
  assign ovf        = (own_fill >= depth_r);

  always_comb begin
    row_new = row;
    if (side_r) begin
      row_new[2*FW-1:FW] = own_fill + 1'b1;
    end else begin
      row_new[FW-1:0] = own_fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      fill_q <= fill_mem[bkt];
      fvld_q <= vld_r[bkt];
    end
    if (cmd.check && !ovf) begin
      fill_mem[bkt] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else if (cmd.check && !ovf) begin
      vld_r[bkt] <= 1'b1;
    end
  end

  // insert into own side, scan the other side one slot a cycle
  assign wr_addr = base + shj_pkg::ADDR_W'(own_fill);
  assign rd_addr = base + shj_pkg::ADDR_W'(s_r);
  assign issue   = cmd.scan && (s_r < scan_r);

  always_ff @(posedge clk) begin
    if (cmd.check && !ovf && !side_r) begin
      lkey_mem[wr_addr] <= key_r;
    end
    if (cmd.check && !ovf && side_r) begin
      rkey_mem[wr_addr] <= key_r;
    end
    if (issue) begin
      key_q <= side_r ? lkey_mem[rd_addr] : rkey_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r  <= 1'b0;
      scan_r <= '0;
    end else if (cmd.load) begin
      ovf_r  <= 1'b0;
      scan_r <= '0;
    end else if (cmd.check) begin
      ovf_r  <= ovf;
      scan_r <= (other_fill > depth_r) ? depth_r : other_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r   <= 1'b0;
      s_r       <= '0;
      matches_r <= '0;
    end else begin
      cmp_v_r <= issue;
      if (cmd.load || cmd.check) begin
        s_r <= '0;
      end else if (issue) begin
        s_r <= s_r + 1'b1;
      end
      if (cmd.load) begin
        matches_r <= '0;
      end else if (cmp_v_r && (key_q == key_r)) begin
        matches_r <= matches_r + 1'b1;
      end
    end
  end

  // batch total, saturating
  assign total_sum = {1'b0, total_r} + (shj_pkg::TOTAL_W + 1)'(matches_r);
  assign total_sat = total_sum[shj_pkg::TOTAL_W] ? '1 : total_sum[shj_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.finish && !op_r) begin
      total_r <= last_r ? '0 : total_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (op_r) begin
        o_match_r <= '0;
        o_batch_r <= total_r;
        o_done_r  <= 1'b0;
        o_ovf_r   <= 1'b0;
      end else begin
        o_match_r <= (32'(matches_r) > 31) ? shj_pkg::MATCH_W'(31)
                                           : shj_pkg::MATCH_W'(matches_r);
        o_batch_r <= total_sat;
        o_done_r  <= last_r;
        o_ovf_r   <= ovf_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_ovf_r, o_batch_r, o_match_r};
  assign out_tlast  = o_done_r;

  assign st.in_op     = in_tuser[0];
  assign st.div_last  = (dcnt_r == shj_pkg::DIVC_W'(shj_pkg::DIV_CYC - 1));
  assign st.scan_more = (s_r < scan_r);
  assign st.cmp_pend  = cmp_v_r;
  assign st.out_free  = !out_valid_r || out_tready;

  `SHJ_ASSERT(a_match_le_slot, matches_r <= s_r, "match count ran ahead of slots read")
  `SHJ_ASSERT(a_slot_le_scan, s_r <= scan_r, "scan went past the probe limit")
  `SHJ_ASSERT_NXT(a_fin_loads, cmd.finish, out_valid_r, "finished item not presented")
  `SHJ_ASSERT_IMP(a_fin_free, cmd.finish, !out_valid_r || out_tready,
                  "result register overwritten before taken")

endmodule

### rtl/symmetric_hash_join_counter.sv
// Channel  Dir  tdata                      tuser        tlast
// in_      in   key[31:0]                  op, side     last_in_batch
// out_     out  tuple_matches[4:0],        -            batch_done
//               batch_matches[36:5],
//               overflow[37], zero[39:38]
// cfg_     in   index 0 bucket_count, index 1 bucket_depth, write only
//
// Insert item: its time from accept to the next accept is set by the key remainder
// unit (8 key bits a cycle) and the single read port of the key store (one slot a
// cycle); 0 to 16 slots are probed, and the next item waits until this one finishes.
// Clear item: goes through the clear state to the finish state.
// Reset is synchronous, active low; all buckets read empty right after it.
// A finished result waits in the output register; the next item is taken meanwhile
// and stalls only at its own finish until out_tready frees the register.
module symmetric_hash_join_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] key
  input  logic [1:0]                  in_tuser,   // [0] op, [1] side
  input  logic                        in_tlast,   // last_in_batch
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // [4:0] tuple_matches, [36:5] batch_matches,
                                                  // [37] overflow, [39:38] zero
  output logic                        out_tlast,  // batch_done
  // configuration
  input  logic                        cfg_we,
  input  logic [shj_pkg::CIDX_W-1:0]  cfg_addr,
  input  logic [shj_pkg::CDATA_W-1:0] cfg_wdata
);

  shj_pkg::cmd_t  cmd;
  shj_pkg::stat_t st;

  // sequencer: hash, fill lookup, insert, probe, clear, result
  shj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // remainder unit, fill and key stores, batch total, result register
  shj_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
